[rtl/core/scld_pkg.sv]
// shared types and character constants for the serial command line decoder
`default_nettype none

package scld_pkg;

    // command codes on the result channel
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ECHO    = 2'd0;
    localparam cmd_t CMD_SPEED   = 2'd1;
    localparam cmd_t CMD_UNKNOWN = 2'd2;

    // control characters
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // the classifier only ever looks at the first few characters of a line
    localparam int unsigned KEEP_CHARS = 5;

    localparam logic [7:0] WORD_ECHO  [4] = '{8'h65, 8'h63, 8'h68, 8'h6F};
    localparam logic [7:0] WORD_SPEED [5] = '{8'h73, 8'h70, 8'h65, 8'h65, 8'h64};

    // length of the finished line, decoded to the cases the classifier cares about
    typedef struct packed {
        logic len_one;
        logic len_four;
        logic len_five;
    } len_flags_t;

    localparam int unsigned LEN_W = 5;
    localparam int unsigned DATA_OUT_W = 8;

endpackage

`default_nettype wire

[rtl/core/scld_classify.sv]
// matches the start of a finished line against the known command words
`default_nettype none

module scld_classify
    import scld_pkg::*;
(
    input  logic [7:0] first_chars [KEEP_CHARS],
    input  len_flags_t len_flags,
    output cmd_t       command
);

    logic is_echo_word;
    logic is_speed_word;
    logic is_e;
    logic is_s;

    always_comb begin
        is_echo_word = len_flags.len_four;
        for (int i = 0; i < 4; i++) begin
            if (first_chars[i] != WORD_ECHO[i]) begin
                is_echo_word = 1'b0;
            end
        end
        is_speed_word = len_flags.len_five;
        for (int i = 0; i < 5; i++) begin
            if (first_chars[i] != WORD_SPEED[i]) begin
                is_speed_word = 1'b0;
            end
        end
        is_e = len_flags.len_one && (first_chars[0] == WORD_ECHO[0]);
        is_s = len_flags.len_one && (first_chars[0] == WORD_SPEED[0]);

        if (is_echo_word || is_e) begin
            command = CMD_ECHO;
        end else if (is_speed_word || is_s) begin
            command = CMD_SPEED;
        end else begin
            command = CMD_UNKNOWN;
        end
    end

endmodule

`default_nettype wire

[rtl/core/serial_command_line_decoder.sv]
// top level of the serial command line decoder
`default_nettype none

// Takes one received serial byte per item on the s_ stream and assembles a
// command line. DEL (0x7F) or BS (0x08) removes the last held character when
// there is one; any other byte except CR and LF is appended while fewer than
// LINE_DEPTH-1 characters are held, and further bytes are dropped. A CR or LF
// ends a non-empty line and produces one item on the m_ stream carrying the
// command (echo for "echo" or "e", speed for "speed" or "s", unknown
// otherwise) and the line length, masked to 5 bits. A CR or LF right after a
// line end is swallowed so CRLF counts once, and an empty line produces
// nothing. Throughput is one byte per cycle while no line end is held back
// by a waiting result: the byte goes into an input register, and the line
// state update plus the compare against the command words run from there
// straight into the result register, which presents the result on m_.
// Only the first five characters of a line are kept, since nothing longer can
// match a command word. With m_tready held low and a result waiting, bytes
// that do not end a line keep flowing at full rate; the next line end waits
// in the input register and s_tready drops until the waiting result is taken.
module serial_command_line_decoder
    import scld_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte

    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata    // [1:0] command, [6:2] line_length, [7] zero
);

    localparam int unsigned CNT_W = $clog2(LINE_DEPTH);
    localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_DEPTH - 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // line state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             skip_reg, skip_next;
    logic [7:0]       chars_reg [KEEP_CHARS];

    // result register
    logic             out_valid_reg, out_valid_next;
    cmd_t             out_cmd_reg;
    logic [LEN_W-1:0] out_len_reg;

    logic advance;          // item in the input register is processed this cycle
    logic is_newline;
    logic is_erase;
    logic emit;
    logic store_en;
    len_flags_t len_flags;
    cmd_t       command;
    logic [EXT_W-1:0] count_ext;

    // the input register moves on unless its item ends a line while an earlier
    // result still waits in the result register
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // line state update for the byte in the input register
    always_comb begin
        is_newline = (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);
        is_erase   = (in_byte_reg == CH_DEL) || (in_byte_reg == CH_BS);
        count_next = count_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        store_en   = 1'b0;
        if (is_newline) begin
            if (skip_reg) begin
                skip_next = 1'b0;
            end else if (count_reg != '0) begin
                emit       = 1'b1;
                count_next = '0;
                skip_next  = 1'b1;
            end
        end else begin
            skip_next = 1'b0;
            if (is_erase) begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end
            end else if (count_reg < CNT_LIMIT) begin
                store_en   = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            skip_reg  <= 1'b0;
        end else if (advance) begin
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

    // keep only the leading characters, each at its own fixed slot
    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEEP_CHARS; i++) begin
            if (advance && store_en && (EXT_W'(count_reg) == EXT_W'(i))) begin
                chars_reg[i] <= in_byte_reg;
            end
        end
    end

    assign count_ext = EXT_W'(count_reg);

    always_comb begin
        len_flags.len_one  = (count_ext == EXT_W'(1));
        len_flags.len_four = (count_ext == EXT_W'(4));
        len_flags.len_five = (count_ext == EXT_W'(5));
    end

    scld_classify u_classify (
        .first_chars (chars_reg),
        .len_flags   (len_flags),
        .command     (command)
    );

    // result register: a new result loads, otherwise a taken result clears
    always_comb begin
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_cmd_reg <= command;
            out_len_reg <= count_ext[LEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_OUT_W - LEN_W - 2){1'b0}}, out_len_reg, out_cmd_reg};

endmodule

`default_nettype wire
